FILE: src/spq_pkg.sv
// Shared types and constants for the stable priority queue.
`default_nettype none
package spq_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int COUNT_W = 5;
	localparam int ID_W    = 16;
	localparam int TYPE_W  = 16;
	localparam int PRIO_W  = 32;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_NULL  = 3'd1,
		ST_DUP   = 3'd2,
		ST_FULL  = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	// one queued entry
	typedef struct packed {
		logic [ID_W-1:0]          id;
		logic [TYPE_W-1:0]        ttype;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t req;
	} cmd_t;

	// compare results a cell reports back
	typedef struct packed {
		logic le;
		logic hit;
	} flags_t;

endpackage
`default_nettype wire

FILE: src/stable_priority_queue.sv
// Top level of the stable priority queue: cell row, checks and result register.
// Bounded priority queue of DEPTH slots kept in ascending signed priority, with
// equal priorities leaving in arrival order. Each operation is carried out in the
// row of slot cells: all cells compare the broadcast id and priority at once
// and shift in the same edge, so busy stays low and a new beat may be started on
// every clock. The result of a beat accepted at one edge is shown for exactly one
// cycle after that edge, marked by done; the receiver cannot stall, so it must
// take the result in that cycle. Slot contents need no clearing after reset.
`default_nettype none
module stable_priority_queue (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               kind,
	input  wire logic [spq_pkg::ID_W-1:0]           item_id,
	input  wire logic [spq_pkg::TYPE_W-1:0]         item_type,
	input  wire logic signed [spq_pkg::PRIO_W-1:0]  priority_req,
	output logic                                    done,
	output logic [2:0]                              status,
	output logic [spq_pkg::COUNT_W-1:0]             count,
	output logic [spq_pkg::ID_W-1:0]                taken_id,
	output logic [spq_pkg::TYPE_W-1:0]              taken_type,
	output logic signed [spq_pkg::PRIO_W-1:0]       taken_priority
);

	logic [spq_pkg::CNT_W-1:0] held_q;
	logic [spq_pkg::CNT_W-1:0] held_d;
	logic                      done_q;
	spq_pkg::status_t          status_q;
	spq_pkg::status_t          status_d;
	spq_pkg::entry_t           taken_q;
	spq_pkg::entry_t           taken_d;

	spq_pkg::cmd_t             cmd;
	spq_pkg::entry_t           entries [spq_pkg::DEPTH];
	spq_pkg::flags_t           flags   [spq_pkg::DEPTH];
	logic [spq_pkg::DEPTH-1:0] hits;
	logic                      accept;
	logic                      dup;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// gather duplicate hits from all cells
	always_comb begin
		for (int i = 0; i < spq_pkg::DEPTH; i++) begin
			hits[i] = flags[i].hit;
		end
	end
	assign dup = |hits;

	// check the beat and build the cell command
	always_comb begin
		status_d      = spq_pkg::ST_OK;
		taken_d       = '0;
		held_d        = held_q;
		cmd.ins       = 1'b0;
		cmd.rem       = 1'b0;
		cmd.req.id    = item_id;
		cmd.req.ttype = item_type;
		cmd.req.prio  = priority_req;
		if (kind == spq_pkg::KIND_INSERT) begin
			if (item_id == '0) begin
				status_d = spq_pkg::ST_NULL;
			end else if (dup) begin
				status_d = spq_pkg::ST_DUP;
			end else if (held_q == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				cmd.ins = accept;
				held_d  = held_q + 1'b1;
			end
		end else begin
			if (held_q == '0) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				cmd.rem = accept;
				taken_d = entries[0];
				held_d  = held_q - 1'b1;
			end
		end
	end

	// row of slot cells, head at index zero
	for (genvar g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
		logic            valid;
		logic            left_le;
		spq_pkg::entry_t left_entry;
		spq_pkg::entry_t right_entry;

		assign valid = (spq_pkg::CNT_W'(g) < held_q);

		if (g == 0) begin : g_head
			assign left_le    = 1'b1;
			assign left_entry = cmd.req;
		end else begin : g_body
			assign left_le    = flags[g-1].le;
			assign left_entry = entries[g-1];
		end

		if (g == spq_pkg::DEPTH - 1) begin : g_tail
			assign right_entry = entries[g];
		end else begin : g_mid
			assign right_entry = entries[g+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.valid       (valid),
			.cmd         (cmd),
			.left_le     (left_le),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entries[g]),
			.flags       (flags[g])
		);
	end

	// advance count and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				held_q <= held_d;
			end
		end
	end

	// hold the result fields of the last beat
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			taken_q  <= taken_d;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign count          = spq_pkg::COUNT_W'(held_q);
	assign taken_id       = taken_q.id;
	assign taken_type     = taken_q.ttype;
	assign taken_priority = taken_q.prio;

endmodule
`default_nettype wire

FILE: src/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
`default_nettype none
module spq_cell (
	input  wire logic            clk,
	input  wire logic            valid,
	input  wire spq_pkg::cmd_t   cmd,
	input  wire logic            left_le,
	input  wire spq_pkg::entry_t left_entry,
	input  wire spq_pkg::entry_t right_entry,
	output spq_pkg::entry_t      entry,
	output spq_pkg::flags_t      flags
);

	spq_pkg::entry_t entry_q;

	// compare held entry against the broadcast request
	always_comb begin
		flags.le  = valid && (entry_q.prio <= cmd.req.prio);
		flags.hit = valid && (entry_q.id == cmd.req.id);
	end

	// keep, take the new entry, shift toward tail, or shift toward head
	always_ff @(posedge clk) begin
		if (cmd.rem) begin
			entry_q <= right_entry;
		end else if (cmd.ins && !flags.le) begin
			if (left_le) begin
				entry_q <= cmd.req;
			end else begin
				entry_q <= left_entry;
			end
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the stable priority queue: directed and random beats.
module testbench;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	// one reply the queue owes for an accepted beat
	typedef struct {
		status_t                  status;
		logic [COUNT_W-1:0]       count;
		logic [ID_W-1:0]          id;
		logic [TYPE_W-1:0]        ttype;
		logic signed [PRIO_W-1:0] prio;
	} reply_t;

	// Mirror of the slot contents plus the replies still owed by the block
	class queue_shadow;
		logic signed [PRIO_W-1:0] slot_prio [DEPTH];
		logic [ID_W-1:0]          slot_id   [DEPTH];
		logic [TYPE_W-1:0]        slot_type [DEPTH];
		int                       held;
		reply_t                   replies_due [$];
		int                       mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		// Apply an accepted command to the mirror and queue the reply it owes
		function void apply_command(logic k, logic [ID_W-1:0] id, logic [TYPE_W-1:0] ty,
				logic signed [PRIO_W-1:0] pr);
			reply_t r;
			logic   dup;
			int     pos;
			r.status = ST_OK;
			r.id = '0;
			r.ttype = '0;
			r.prio = '0;
			dup = 1'b0;
			if (k == KIND_INSERT) begin
				for (int i = 0; i < held; i++)
					if (slot_id[i] == id)
						dup = 1'b1;
				if (id == '0) begin
					r.status = ST_NULL;
				end else if (dup) begin
					r.status = ST_DUP;
				end else if (held >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// place after every entry of lower or equal priority
					pos = 0;
					while (pos < held && slot_prio[pos] <= pr)
						pos++;
					for (int i = held; i > pos; i--) begin
						slot_prio[i] = slot_prio[i-1];
						slot_id[i]   = slot_id[i-1];
						slot_type[i] = slot_type[i-1];
					end
					slot_prio[pos] = pr;
					slot_id[pos]   = id;
					slot_type[pos] = ty;
					held++;
				end
			end else begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// hand back the head and advance the rest
					r.id    = slot_id[0];
					r.ttype = slot_type[0];
					r.prio  = slot_prio[0];
					for (int i = 1; i < held; i++) begin
						slot_prio[i-1] = slot_prio[i];
						slot_id[i-1]   = slot_id[i];
						slot_type[i-1] = slot_type[i];
					end
					held--;
				end
			end
			r.count = COUNT_W'(held);
			replies_due.push_back(r);
		endfunction

		// Compare one reply beat against the oldest owed reply
		function void match_reply(logic [2:0] st, logic [COUNT_W-1:0] cnt, logic [ID_W-1:0] id,
				logic [TYPE_W-1:0] ty, logic signed [PRIO_W-1:0] pr);
			reply_t r;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] reply beat with nothing owed: status %0d count %0d",
						$realtime, st, cnt);
				return;
			end
			r = replies_due.pop_front();
			if (st !== r.status || cnt !== r.count || id !== r.id || ty !== r.ttype
					|| pr !== r.prio) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] reply mismatch", $realtime);
					$display("  expected status %0d count %0d id %h type %h prio %0d",
						r.status, r.count, r.id, r.ttype, r.prio);
					$display("  actual   status %0d count %0d id %h type %h prio %0d",
						st, cnt, id, ty, pr);
				end
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     kind = KIND_INSERT;
	logic [ID_W-1:0]          item_id = '0;
	logic [TYPE_W-1:0]        item_type = '0;
	logic signed [PRIO_W-1:0] priority_req = '0;
	logic                     busy;
	logic                     done;
	logic [2:0]               status;
	logic [COUNT_W-1:0]       count;
	logic [ID_W-1:0]          taken_id;
	logic [TYPE_W-1:0]        taken_type;
	logic signed [PRIO_W-1:0] taken_priority;
	int                       cycles = 0;

	queue_shadow shadow = new();

	stable_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.item_id(item_id),
		.item_type(item_type),
		.priority_req(priority_req),
		.done(done),
		.status(status),
		.count(count),
		.taken_id(taken_id),
		.taken_type(taken_type),
		.taken_priority(taken_priority)
	);

	always #5 clk = ~clk;

	// Check reply beats, then note accepted command beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				shadow.match_reply(status, count, taken_id, taken_type, taken_priority);
			if (start && !busy)
				shadow.apply_command(kind, item_id, item_type, priority_req);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("stable_priority_queue verification failed");
			$finish;
		end
	end

	// Drive one command beat, hold it until accepted, then idle for the given gap
	task automatic send_beat(input logic k, input logic [ID_W-1:0] id,
			input logic [TYPE_W-1:0] ty, input logic signed [PRIO_W-1:0] pr, input int gap);
		start        <= 1'b1;
		kind         <= k;
		item_id      <= id;
		item_type    <= ty;
		priority_req <= pr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every owed reply has arrived
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (shadow.replies_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Random beat: ids from a small pool for duplicates, priorities clustered for ties
	task automatic random_beat(input int ins_pct, input bit calm);
		logic                     k;
		logic [ID_W-1:0]          id;
		logic signed [PRIO_W-1:0] pr;
		int                       s;
		k = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
		s = $urandom_range(0, 99);
		if (s < 3)
			id = '0;
		else if (s < 80)
			id = ID_W'($urandom_range(1, 40));
		else
			id = ID_W'($urandom);
		s = $urandom_range(0, 99);
		if (s < 40)
			pr = $signed($urandom_range(0, 4)) - 2;
		else if (s < 55)
			case ($urandom_range(0, 3))
				0: pr = 32'sh8000_0000;
				1: pr = 32'sh7fff_ffff;
				2: pr = -1;
				default: pr = 0;
			endcase
		else
			pr = $urandom;
		send_beat(k, id, TYPE_W'($urandom), pr, pick_gap(calm));
	endtask

	initial begin
		int ins_pct;
		bit calm;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty remove, null, extremes, duplicate, ties
		send_beat(KIND_REMOVE, 16'h1234, 16'h5678, 32'sh1234_5678, 0);
		send_beat(KIND_INSERT, 16'h0000, 16'hffff, 32'sh7fff_ffff, 1);
		send_beat(KIND_INSERT, 16'hffff, 16'hffff, 32'sh8000_0000, 0);
		send_beat(KIND_INSERT, 16'hffff, 16'h0001, 32'sh0000_0000, 0);
		send_beat(KIND_INSERT, 16'h0001, 16'h0000, 32'sh7fff_ffff, 2);
		send_beat(KIND_INSERT, 16'h0002, 16'haaaa, 32'sd5, 0);
		send_beat(KIND_INSERT, 16'h0003, 16'h5555, 32'sd5, 0);
		send_beat(KIND_REMOVE, 16'hffff, 16'hffff, 32'sh7fff_ffff, 0);
		// fill to capacity with clustered priorities
		for (int i = 0; i < 13; i++)
			send_beat(KIND_INSERT, ID_W'(16 + i), TYPE_W'(i), PRIO_W'((i % 4) - 2), i % 2);
		// full, then null and duplicate on a full queue
		send_beat(KIND_INSERT, 16'd100, 16'h0f0f, -1, 0);
		send_beat(KIND_INSERT, 16'h0000, 16'h0f0f, -1, 0);
		send_beat(KIND_INSERT, 16'h0001, 16'h0f0f, -1, 0);
		send_beat(KIND_REMOVE, 16'h0000, 16'h0000, 0, 0);
		settle();

		// random: phases of varying insert bias, some without idling
		for (int blk = 0; blk < 17; blk++) begin
			case ($urandom_range(0, 2))
				0: ins_pct = 35;
				1: ins_pct = 55;
				default: ins_pct = 80;
			endcase
			calm = ($urandom_range(0, 3) == 0);
			repeat (50) random_beat(ins_pct, calm);
			if (blk % 4 == 3)
				settle();
		end

		// drain and let the last reply land
		settle();
		repeat (4) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.replies_due.size() == 0)
			$display("stable_priority_queue verification clean");
		else
			$display("stable_priority_queue verification failed");
		$finish;
	end

endmodule

FILE: files.f
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_queue.sv
sim/testbench.sv
